FILE: rtl/vesp_pkg.sv
// shared constants and helpers for the vessel state prediction pipeline
`timescale 1ns / 1ps
package vesp_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TRIG_FRAC         = 30;
  localparam int NUM_REGS          = 8;

  localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
  localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [30:0] STEP_TIME_RESET = 31'd6554;

  typedef enum logic [2:0] {
    REG_STEP_TIME  = 3'd0,
    REG_SURGE_QUAD = 3'd1,
    REG_SURGE_LIN  = 3'd2,
    REG_SURGE_CROSS = 3'd3,
    REG_YAW_CROSS  = 3'd4,
    REG_YAW_LIN    = 3'd5,
    REG_YAW_QUAD   = 3'd6,
    REG_THRUST     = 3'd7
  } reg_idx_t;

  // arctangent table, 30 fraction bits
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_q30 = 32'd843314857;
      5'd1:  atan_q30 = 32'd497837829;
      5'd2:  atan_q30 = 32'd263043837;
      5'd3:  atan_q30 = 32'd133525158;
      5'd4:  atan_q30 = 32'd67021687;
      5'd5:  atan_q30 = 32'd33543516;
      5'd6:  atan_q30 = 32'd16775851;
      5'd7:  atan_q30 = 32'd8388438;
      5'd8:  atan_q30 = 32'd4194283;
      5'd9:  atan_q30 = 32'd2097150;
      5'd10: atan_q30 = 32'd1048576;
      5'd11: atan_q30 = 32'd524288;
      5'd12: atan_q30 = 32'd262144;
      5'd13: atan_q30 = 32'd131072;
      5'd14: atan_q30 = 32'd65536;
      5'd15: atan_q30 = 32'd32768;
      5'd16: atan_q30 = 32'd16384;
      5'd17: atan_q30 = 32'd8192;
      5'd18: atan_q30 = 32'd4096;
      5'd19: atan_q30 = 32'd2048;
      5'd20: atan_q30 = 32'd1024;
      5'd21: atan_q30 = 32'd512;
      5'd22: atan_q30 = 32'd256;
      5'd23: atan_q30 = 32'd128;
      default: atan_q30 = 32'd0;
    endcase
  endfunction

  // saturate a 66 bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (x < -66'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = x[31:0];
  endfunction

endpackage

FILE: rtl/vesp_cordic.sv
// pipelined rotation cordic producing cos and sin with 30 fraction bits
`timescale 1ns / 1ps
module vesp_cordic import vesp_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] z_in,
  input  logic [1:0]         quad_in,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);

  logic signed [33:0] x_r [2:CORDIC_STAGES];
  logic signed [33:0] y_r [2:CORDIC_STAGES];
  logic signed [33:0] z_r [2:CORDIC_STAGES];
  logic [1:0]         q_r [2:CORDIC_STAGES];

  // first iteration starts from (gain, 0), so only y and z depend on the sign
  // first stage is folded into the input register of the next
  logic signed [33:0] gain, at0, x1, y1, z1;
  always_comb begin
    gain = $signed({2'b00, CORDIC_GAIN_Q30});
    at0  = $signed({2'b00, atan_q30(5'd0)});
    x1   = gain;
    if (!z_in[33]) begin
      y1 = gain;
      z1 = z_in - at0;
    end else begin
      y1 = -gain;
      z1 = z_in + at0;
    end
  end

  for (genvar i = 1; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [33:0] xi, yi, zi;
    logic [1:0]         qi;
    logic signed [33:0] x_nxt, y_nxt, z_nxt;
    logic signed [33:0] at;
    if (i == 1) begin : g_src
      assign xi = x1;
      assign yi = y1;
      assign zi = z1;
      assign qi = quad_in;
    end else begin : g_src
      assign xi = x_r[i];
      assign yi = y_r[i];
      assign zi = z_r[i];
      assign qi = q_r[i];
    end
    always_comb begin
      at = $signed({2'b00, atan_q30(5'(i))});
      if (!zi[33]) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - at;
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + at;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
        q_r[i+1] <= qi;
      end
    end
  end

  always_comb begin
    unique case (q_r[CORDIC_STAGES])
      2'd1:    begin cos_out = -y_r[CORDIC_STAGES]; sin_out =  x_r[CORDIC_STAGES]; end
      2'd2:    begin cos_out = -x_r[CORDIC_STAGES]; sin_out = -y_r[CORDIC_STAGES]; end
      2'd3:    begin cos_out =  y_r[CORDIC_STAGES]; sin_out = -x_r[CORDIC_STAGES]; end
      default: begin cos_out =  x_r[CORDIC_STAGES]; sin_out =  y_r[CORDIC_STAGES]; end
    endcase
  end

endmodule

FILE: rtl/vessel_ekf_state_prediction.sv
// top level of the vessel state prediction pipeline
`timescale 1ns / 1ps
// Predicts the next 3-dof vessel state from one state item and a thrust command.
// One request enters per cycle unless the output stalls; the pipeline stages are:
// the phase multiply, the residue multiply, the sine/cosine cordic chain
// (first two iterations share a register, then one per iteration, so
// CORDIC_STAGES-1 registers), the rotation products, the world velocity, the
// step-time products and the final sums. A stall at the output freezes the
// whole pipeline, so requests are neither lost nor repeated; in_stall is simply
// out_stall while the last stage holds a result.
// Coefficient registers may be written only while the pipe is empty.
module vessel_ekf_state_prediction import vesp_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_heading,
  input  logic signed [31:0] in_surge_speed,
  input  logic signed [31:0] in_sway_speed,
  input  logic signed [31:0] in_yaw_rate,
  input  logic signed [31:0] in_current_x,
  input  logic signed [31:0] in_current_y,
  input  logic signed [31:0] in_thrust,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_next_pos_x,
  output logic signed [31:0] out_next_pos_y,
  output logic signed [31:0] out_next_heading,
  output logic signed [31:0] out_next_surge,
  output logic signed [31:0] out_next_sway,
  output logic signed [31:0] out_next_yaw_rate,
  output logic signed [31:0] out_next_current_x,
  output logic signed [31:0] out_next_current_y
);

  // stage plan: s1 phase product, s2 residue product, cordic (stages-1 regs),
  // s3 rotation products, s4 world velocity, s5 step products, s6 sums
  localparam int CDLY  = CORDIC_STAGES - 1;
  localparam int DEPTH = CORDIC_STAGES + 5;

  // configuration registers
  logic [30:0]        dt_r;
  logic signed [31:0] aq_r, al_r, ac_r, yc_r, yl_r, yq_r, g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= STEP_TIME_RESET;
      aq_r <= '0; al_r <= '0; ac_r <= '0; yc_r <= '0;
      yl_r <= '0; yq_r <= '0; g_r  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_TIME:   dt_r <= cfg_data[30:0];
        REG_SURGE_QUAD:  aq_r <= cfg_data;
        REG_SURGE_LIN:   al_r <= cfg_data;
        REG_SURGE_CROSS: ac_r <= cfg_data;
        REG_YAW_CROSS:   yc_r <= cfg_data;
        REG_YAW_LIN:     yl_r <= cfg_data;
        REG_YAW_QUAD:    yq_r <= cfg_data;
        REG_THRUST:      g_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid chain, whole pipe advances together
  logic [DEPTH-1:0] vld_r;
  logic             en;
  assign en       = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DEPTH-2:0], in_valid};
  end

  // fixed-point product helper: 32x32 exact, floor shift, saturate
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    qmul = sat32(66'(p >>> FRAC_BITS));
  endfunction

  // ---------------- stage 1: phase product, speed terms, first products
  logic [31:0]        ph1_r;
  logic signed [31:0] hd1_r, u1_r, v1_r, r1_r, cx1_r, cy1_r, px1_r, py1_r;
  logic signed [32:0] fu1_r, fv1_r;
  logic signed [31:0] rr1_r, aru1_r, ur1_r, arr1_r, gt1_r, alu1_r, ylr1_r;
  logic signed [63:0] turns;
  logic signed [31:0] ar;

  always_comb begin
    turns = in_heading * $signed({1'b0, INV_TWO_PI_Q32[30:0]});
    ar    = (in_yaw_rate == 32'sh80000000) ? 32'sh7fffffff
          : (in_yaw_rate[31] ? -in_yaw_rate : in_yaw_rate);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph1_r  <= turns[FRAC_BITS +: 32];
      hd1_r  <= in_heading;  u1_r <= in_surge_speed; v1_r <= in_sway_speed;
      r1_r   <= in_yaw_rate; cx1_r <= in_current_x;  cy1_r <= in_current_y;
      px1_r  <= in_pos_x;    py1_r <= in_pos_y;
      fu1_r  <= 33'(in_surge_speed) + 33'(in_current_x);
      fv1_r  <= 33'(in_sway_speed) + 33'(in_current_y);
      rr1_r  <= qmul(in_yaw_rate, in_yaw_rate);
      aru1_r <= qmul(ar, in_surge_speed);
      ur1_r  <= qmul(in_surge_speed, in_yaw_rate);
      arr1_r <= qmul(ar, in_yaw_rate);
      gt1_r  <= qmul(g_r, in_thrust);
      alu1_r <= qmul(al_r, in_surge_speed);
      ylr1_r <= qmul(yl_r, in_yaw_rate);
    end
  end

  // ---------------- stage 2: residue scaling, coefficient products
  logic [1:0]         quad;
  logic signed [31:0] resid;
  logic signed [63:0] zp;
  logic signed [33:0] z2_r;
  logic [1:0]         q2_r;
  // five full-range terms in the surge sum need 35 bits
  logic signed [34:0] nu2_r;
  logic signed [33:0] nr2_r;

  always_comb begin
    quad  = 2'((ph1_r + 32'h20000000) >> 30);
    resid = $signed(ph1_r - {quad, 30'd0});
    zp    = resid * $signed({1'b0, HALF_PI_Q30[30:0]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z2_r  <= 34'(zp >>> TRIG_FRAC);
      q2_r  <= quad;
      nu2_r <= 35'(u1_r) - 35'(qmul(aq_r, rr1_r)) - 35'(alu1_r)
             - 35'(qmul(ac_r, aru1_r)) + 35'(gt1_r);
      nr2_r <= 34'(r1_r) + 34'(qmul(yc_r, ur1_r)) - 34'(ylr1_r)
             - 34'(qmul(yq_r, arr1_r));
    end
  end

  // ---------------- cordic
  logic signed [33:0] cos_w, sin_w;
  vesp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .en(en), .z_in(z2_r), .quad_in(q2_r),
    .cos_out(cos_w), .sin_out(sin_w)
  );

  // side data delayed alongside the cordic; item at stage 2 reaches d_r[CDLY]
  typedef struct packed {
    logic signed [31:0] px, py, hd, v, r, cx, cy, nu, nr;
    logic signed [32:0] fu, fv;
  } side_t;

  side_t d_r [CDLY+1];
  side_t d1_nxt;

  // surge and yaw sums sit in s2 together with d_r[0], so they join at d_r[1]
  always_comb begin
    d1_nxt    = d_r[0];
    d1_nxt.nu = sat32(66'(nu2_r));
    d1_nxt.nr = sat32(66'(nr2_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= '{px: px1_r, py: py1_r, hd: hd1_r, v: v1_r, r: r1_r,
                  cx: cx1_r, cy: cy1_r, nu: 32'sd0, nr: 32'sd0,
                  fu: fu1_r, fv: fv1_r};
      d_r[1] <= d1_nxt;
      for (int k = 2; k <= CDLY; k++) d_r[k] <= d_r[k-1];
    end
  end
  // d_r[0] is one stage behind s1, aligned with s2; tail lines up with cordic out
  side_t sd;
  assign sd = d_r[CDLY];

  // ---------------- stage 3: rotation products
  logic signed [63:0] fuc3_r, fvs3_r, fus3_r, fvc3_r;
  side_t s3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      fuc3_r <= 64'((67'(sd.fu) * 67'(cos_w)) >>> TRIG_FRAC);
      fvs3_r <= 64'((67'(sd.fv) * 67'(sin_w)) >>> TRIG_FRAC);
      fus3_r <= 64'((67'(sd.fu) * 67'(sin_w)) >>> TRIG_FRAC);
      fvc3_r <= 64'((67'(sd.fv) * 67'(cos_w)) >>> TRIG_FRAC);
      s3_r   <= sd;
    end
  end

  // ---------------- stage 4: world velocity
  logic signed [31:0] wx4_r, wy4_r;
  side_t s4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      wx4_r <= sat32(66'(fuc3_r) - 66'(fvs3_r));
      wy4_r <= sat32(66'(fus3_r) + 66'(fvc3_r));
      s4_r  <= s3_r;
    end
  end

  // ---------------- stage 5: step-time products
  logic signed [63:0] dx5_r, dy5_r, dh5_r;
  side_t s5_r;
  logic signed [31:0] dts;
  assign dts = $signed({1'b0, dt_r});
  always_ff @(posedge clk) begin
    if (en) begin
      dx5_r <= (wx4_r * dts) >>> FRAC_BITS;
      dy5_r <= (wy4_r * dts) >>> FRAC_BITS;
      dh5_r <= (s4_r.r * dts) >>> FRAC_BITS;
      s5_r  <= s4_r;
    end
  end

  // ---------------- stage 6: final sums
  always_ff @(posedge clk) begin
    if (en) begin
      out_next_pos_x     <= sat32(66'(s5_r.px) + 66'(dx5_r));
      out_next_pos_y     <= sat32(66'(s5_r.py) + 66'(dy5_r));
      out_next_heading   <= sat32(66'(s5_r.hd) + 66'(dh5_r));
      out_next_surge     <= s5_r.nu;
      out_next_sway      <= s5_r.v;
      out_next_yaw_rate  <= s5_r.nr;
      out_next_current_x <= s5_r.cx;
      out_next_current_y <= s5_r.cy;
    end
  end

endmodule

FILE: verif/tb_vessel_ekf_state_prediction.sv
// self-checking testbench for the vessel state prediction pipeline
`timescale 1ns / 1ps
module tb_vessel_ekf_state_prediction;
  import vesp_pkg::*;

  localparam int FRAC = 16;
  localparam int STAGES = 16;
  localparam int PIPE_DEPTH = STAGES + 5;
  localparam int N_RANDOM = 480;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, heading, surge, sway, yaw_rate, cur_x, cur_y, thrust;
  } vessel_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x, pos_y, heading, surge, sway, yaw_rate, cur_x, cur_y;
  } vessel_state_t;

  // directed row: request, plus an optional typed-in expectation
  typedef struct {
    vessel_req_t req;
    bit has_fixed;
    vessel_state_t fixed;
  } directed_row_t;

  logic clk, rst_n;
  logic cfg_we;
  reg_idx_t cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  vessel_req_t in_req;
  vessel_state_t out_st;

  vessel_ekf_state_prediction dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_req.pos_x), .in_pos_y(in_req.pos_y), .in_heading(in_req.heading),
    .in_surge_speed(in_req.surge), .in_sway_speed(in_req.sway),
    .in_yaw_rate(in_req.yaw_rate), .in_current_x(in_req.cur_x),
    .in_current_y(in_req.cur_y), .in_thrust(in_req.thrust),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_next_pos_x(out_st.pos_x), .out_next_pos_y(out_st.pos_y),
    .out_next_heading(out_st.heading), .out_next_surge(out_st.surge),
    .out_next_sway(out_st.sway), .out_next_yaw_rate(out_st.yaw_rate),
    .out_next_current_x(out_st.cur_x), .out_next_current_y(out_st.cur_y)
  );

  // shadow copy of the coefficient registers
  longint step_time_q;
  longint coef_q[7];

  vessel_state_t predicted_states[$];
  int mismatch_count;
  int results_seen;
  longint cycle_count;
  bit hold_off_req;     // sender asks the receiver for a long stall
  bit hold_off_done;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------
  function automatic longint floor_shift(longint x, int n);
    return x >>> n;   // arithmetic shift rounds toward minus infinity
  endfunction

  function automatic longint clamp32(longint x);
    if (x > S32_HI) return S32_HI;
    if (x < S32_LO) return S32_LO;
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clamp32(floor_shift(a * b, FRAC));
  endfunction

  // cordic sine/cosine of a Q16.16 angle, results with 30 fraction bits
  function automatic void heading_trig(input longint ang, output longint c, output longint s);
    longint atan_tab[16];
    logic [63:0] turns;
    logic [31:0] phase, resid_u;
    logic [1:0] quad;
    longint resid, z, x, y, nx;
    atan_tab = '{843314857, 497837829, 263043837, 133525158, 67021687, 33543516,
                 16775851, 8388438, 4194283, 2097150, 1048576, 524288,
                 262144, 131072, 65536, 32768};
    turns = ang * 64'sd683565276;
    phase = turns[FRAC +: 32];
    quad = 2'((phase + 32'h2000_0000) >> 30);
    resid_u = phase - ({30'd0, quad} << 30);
    resid = longint'($signed(resid_u));
    z = floor_shift(resid * 64'sd1686629713, 30);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= atan_tab[i];
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += atan_tab[i];
      end
      x = nx;
    end
    case (quad)
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      2'd3: begin c = y; s = -x; end
      default: begin c = x; s = y; end
    endcase
  endfunction

  function automatic vessel_state_t predict_next_state(vessel_req_t q);
    vessel_state_t n;
    longint px, py, hd, u, v, r, cx, cy, th;
    longint c, s, fu, fv, wx, wy, ar, nu, nr;
    px = q.pos_x; py = q.pos_y; hd = q.heading;
    u = q.surge; v = q.sway; r = q.yaw_rate;
    cx = q.cur_x; cy = q.cur_y; th = q.thrust;
    heading_trig(hd, c, s);
    fu = u + cx;
    fv = v + cy;
    wx = clamp32(floor_shift(fu * c, 30) - floor_shift(fv * s, 30));
    wy = clamp32(floor_shift(fu * s, 30) + floor_shift(fv * c, 30));
    // |most negative| saturates to the largest positive value
    ar = clamp32(r < 0 ? -r : r);
    nu = u - fx_mul(coef_q[0], fx_mul(r, r)) - fx_mul(coef_q[1], u)
         - fx_mul(coef_q[2], fx_mul(ar, u)) + fx_mul(coef_q[6], th);
    nr = r + fx_mul(coef_q[3], fx_mul(u, r)) - fx_mul(coef_q[4], r)
         - fx_mul(coef_q[5], fx_mul(ar, r));
    n.pos_x = 32'(clamp32(px + floor_shift(wx * step_time_q, FRAC)));
    n.pos_y = 32'(clamp32(py + floor_shift(wy * step_time_q, FRAC)));
    n.heading = 32'(clamp32(hd + floor_shift(r * step_time_q, FRAC)));
    n.surge = 32'(clamp32(nu));
    n.sway = q.sway;
    n.yaw_rate = 32'(clamp32(nr));
    n.cur_x = q.cur_x;
    n.cur_y = q.cur_y;
    return n;
  endfunction

  // ---------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
  endtask

  task automatic compare_state(vessel_state_t got, vessel_state_t want);
    if (got.pos_x !== want.pos_x) report_mismatch("next_pos_x", got.pos_x, want.pos_x);
    if (got.pos_y !== want.pos_y) report_mismatch("next_pos_y", got.pos_y, want.pos_y);
    if (got.heading !== want.heading)
      report_mismatch("next_heading", got.heading, want.heading);
    if (got.surge !== want.surge) report_mismatch("next_surge", got.surge, want.surge);
    if (got.sway !== want.sway) report_mismatch("next_sway", got.sway, want.sway);
    if (got.yaw_rate !== want.yaw_rate)
      report_mismatch("next_yaw_rate", got.yaw_rate, want.yaw_rate);
    if (got.cur_x !== want.cur_x) report_mismatch("next_current_x", got.cur_x, want.cur_x);
    if (got.cur_y !== want.cur_y) report_mismatch("next_current_y", got.cur_y, want.cur_y);
  endtask

  // output monitor: sample accepted results at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (predicted_states.size() == 0) begin
        report_mismatch("unexpected result, next_pos_x", out_st.pos_x, 32'h0);
      end else begin
        compare_state(out_st, predicted_states.pop_front());
      end
    end
  end

  // receiver: random stall per result, plus one long hold-off on request
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        // long stall so the pipe fills and backs up into the input
        out_stall <= 1'b1;
        repeat (PIPE_DEPTH * 4) @(posedge clk);
        hold_off_done = 1'b1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  // cycle budget
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  // write enable stays high for back-to-back writes; caller drops it
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_STEP_TIME) step_time_q = longint'(val[30:0]);
    else coef_q[int'(idx) - 1] = longint'($signed(val));
  endtask

  // pipe drained and settled before touching registers
  task automatic wait_idle();
    while (predicted_states.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // one request; gap drawn per item, expected state queued on acceptance
  // valid stays high after acceptance; caller drops it after the last one
  task automatic send_request(vessel_req_t q, bit use_gap, bit has_fixed, vessel_state_t fixed);
    int gap;
    gap = (use_gap && $urandom_range(0, 2) != 0) ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_states.push_back(has_fixed ? fixed : predict_next_state(q));
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return $urandom();
    endcase
  endfunction

  function automatic vessel_req_t rand_request();
    vessel_req_t q;
    q.pos_x = rand_field(); q.pos_y = rand_field(); q.heading = rand_field();
    q.surge = rand_field(); q.sway = rand_field(); q.yaw_rate = rand_field();
    q.cur_x = rand_field(); q.cur_y = rand_field(); q.thrust = rand_field();
    return q;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    vessel_state_t none;
    int pass_idx;
    mismatch_count = 0;
    results_seen = 0;
    cycle_count = 0;
    hold_off_req = 0;
    hold_off_done = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_STEP_TIME;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req = '0;
    none = '0;
    step_time_q = 6554;
    for (int i = 0; i < 7; i++) coef_q[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero state after reset: heading 0, no motion, everything stays zero
    row.req = '0; row.has_fixed = 1; row.fixed = '0; rows.push_back(row);
    // held fields pass through at the extremes, reset coefficients zero
    row.req = '0;
    row.req.sway = 32'h7fff_ffff; row.req.cur_x = 32'h8000_0000;
    row.req.cur_y = 32'h7fff_ffff; row.req.cur_x = 32'h8000_0000;
    row.req.pos_x = 32'h7fff_ffff; row.req.pos_y = 32'h8000_0000;
    row.has_fixed = 0; row.fixed = none; rows.push_back(row);
    // heading saturates upward and downward without wrap
    row.req = '0; row.req.heading = 32'h7fff_ffff; row.req.yaw_rate = 32'h7fff_ffff;
    row.has_fixed = 1; row.fixed = '0;
    row.fixed.heading = 32'h7fff_ffff;
    row.fixed.yaw_rate = 32'h7fff_ffff; rows.push_back(row);
    row.req = '0; row.req.heading = 32'h8000_0000; row.req.yaw_rate = 32'h8000_0000;
    row.has_fixed = 1; row.fixed = '0;
    row.fixed.heading = 32'h8000_0000;
    row.fixed.yaw_rate = 32'h8000_0000; rows.push_back(row);
    // headings around each quarter turn and negative angles
    for (int k = -4; k <= 4; k++) begin
      row.req = '0;
      row.req.heading = 32'(k * 102944);   // about k*pi/2 in Q16.16
      row.req.surge = 32'sh0001_0000; row.req.sway = 32'sh0000_8000;
      row.req.cur_x = 32'sh0000_4000; row.req.cur_y = -32'sh0000_2000;
      row.has_fixed = 0; rows.push_back(row);
    end
    for (int k = 0; k < 8; k++) begin
      row.req = rand_request(); row.has_fixed = 0; rows.push_back(row);
    end

    foreach (rows[i]) send_request(rows[i].req, 0, rows[i].has_fixed, rows[i].fixed);
    in_valid <= 1'b0;
    wait_idle();

    // several register settings: extremes, then random ones
    for (pass_idx = 0; pass_idx < 6; pass_idx++) begin
      case (pass_idx)
        0: begin
          write_reg(REG_STEP_TIME, 32'h7fff_ffff);
          for (int r = 1; r < 8; r++) write_reg(reg_idx_t'(r), 32'h7fff_ffff);
        end
        1: begin
          write_reg(REG_STEP_TIME, 32'h0000_0000);
          for (int r = 1; r < 8; r++) write_reg(reg_idx_t'(r), 32'h8000_0000);
        end
        2: begin
          // high bit of step time write is dropped
          write_reg(REG_STEP_TIME, 32'hffff_ffff);
          for (int r = 1; r < 8; r++) write_reg(reg_idx_t'(r), 32'h0000_0000);
        end
        default: begin
          write_reg(REG_STEP_TIME, $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 1 << 17)));
          for (int r = 1; r < 8; r++) write_reg(reg_idx_t'(r), rand_coef());
        end
      endcase
      cfg_we <= 1'b0;
      @(posedge clk);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        if (pass_idx == 3 && n == 10) hold_off_req = 1;  // sender keeps offering
        if (pass_idx == 4 && n == 20) begin
          // sender pause until every expected result has come
          in_valid <= 1'b0;
          @(posedge clk);
          while (predicted_states.size() != 0) @(posedge clk);
        end
        // runs with no idling on alternate stretches
        send_request(rand_request(), ((n / 20) % 2) == 0, 0, none);
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    while (predicted_states.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    $display("covered %0d results over six register settings, extreme fields and angles,",
             results_seen);
    $display("random stalls on both sides and one long output hold-off");
    if (mismatch_count == 0 && predicted_states.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/vesp_pkg.sv
rtl/vesp_cordic.sv
rtl/vessel_ekf_state_prediction.sv
verif/tb_vessel_ekf_state_prediction.sv
